// ===== hdl/oahs_pkg.sv =====
// ----------------------------------------------------------------------------
// oahs_pkg
// Shared types and codes for the open-addressed hash set.
// ----------------------------------------------------------------------------
package oahs_pkg;

  localparam int unsigned TableSize = 1024;
  localparam int unsigned KeyBits = 32;
  localparam int unsigned HashBits = 32;

  localparam int unsigned FuncW = 2;
  localparam int unsigned PrimeW = 11;
  localparam int unsigned SizeLogW = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned BidxW = 10;
  localparam int unsigned OutKeyW = 32;
  localparam int unsigned CountW = 11;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 11;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_RSVD      = 2'd3
  } status_e;

  localparam logic [CfgAddrW-1:0] CFG_PRIME = 1'd0;
  localparam logic [CfgAddrW-1:0] CFG_SIZE  = 1'd1;

  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [KeyBits-1:0]  key;
    logic [HashBits-1:0] key_hash;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [StatusW-1:0] status;
    logic [BidxW-1:0]   bucket_index;
    logic [OutKeyW-1:0] stored_key;
    logic [CountW-1:0]  entry_count;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic first_probe;
    logic next_probe;
    logic read;
    logic clr_step;
    logic commit;
    logic emit_clear;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_done;
    logic empty;
    logic match;
    logic last_probe;
    logic clr_done;
  } dp_sts_t;

endpackage

// ===== hdl/oahs_ctrl.sv =====
// ----------------------------------------------------------------------------
// oahs_ctrl
// Sequencer for one request: modulo, probe walk, update and result, or a clear sweep; also the clear after reset.
// ----------------------------------------------------------------------------
module oahs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [1:0]        func_i,
  input  logic              rsp_busy_i,
  output oahs_pkg::dp_cmd_t cmd_o,
  input  oahs_pkg::dp_sts_t sts_i
);
  import oahs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_EVAL  = 7'b0001000,
    ST_CLEAR = 7'b0010000,
    ST_DONE  = 7'b0100000,
    ST_INIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   clr_req;

  assign req_ready_o = (state_q == ST_IDLE) && !rsp_busy_i;
  assign clr_req = (func_i == FUNC_CLEAR);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = clr_req ? ST_CLEAR : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.first_probe = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.empty || sts_i.match || sts_i.last_probe) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.next_probe = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.emit_clear = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_commit_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> state_q == ST_EVAL) else $error("commit outside evaluation");
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> req_ready_o) else $error("load without ready");

endmodule

// ===== hdl/oahs_dp.sv =====
// ----------------------------------------------------------------------------
// oahs_dp
// Bucket memories, restoring divider, probe index and result register.
// ----------------------------------------------------------------------------
module oahs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    func_i,
  input  logic [oahs_pkg::KeyBits-1:0]  key_i,
  input  logic [oahs_pkg::HashBits-1:0] key_hash_i,
  input  logic [10:0]                   prime_i,
  input  logic [3:0]                    size_log2_i,
  input  oahs_pkg::dp_cmd_t             cmd_i,
  output oahs_pkg::dp_sts_t             sts_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output oahs_pkg::rsp_t                rsp_o
);
  import oahs_pkg::*;

  localparam int unsigned IdxW = (TableSize > 1) ? $clog2(TableSize) : 1;
  localparam int unsigned HCntW = $clog2(HashBits + 1);
  localparam int unsigned TCntW = $clog2(TableSize + 1);
  localparam logic [SizeLogW-1:0] LMax = SizeLogW'(IdxW);

  logic [HashBits-1:0] hash_mem [TableSize];
  logic [KeyBits-1:0]  key_mem  [TableSize];

  logic [1:0]          func_q;
  logic [KeyBits-1:0]  key_q;
  logic [HashBits-1:0] hash_q, quot_q;
  logic [10:0]         prime_q, rem_q;
  logic [HCntW-1:0]    div_cnt_q;
  logic [IdxW-1:0]     mask_q, idx_q;
  logic [TCntW-1:0]    step_q, size_q;
  logic [HashBits-1:0] rd_hash_q;
  logic [KeyBits-1:0]  rd_key_q;
  logic [IdxW-1:0]     clr_idx_q;
  logic [CountW-1:0]   count_q;
  logic                rsp_valid_q;
  rsp_t                rsp_q;

  logic [11:0]         rem_sh;
  logic [3:0]          lsat;
  logic                match, empty;

  assign rem_sh = {rem_q, quot_q[HashBits-1]};
  assign lsat = (size_log2_i == '0) ? 4'd1 : ((size_log2_i > LMax) ? LMax : size_log2_i);
  assign empty = (rd_hash_q == '0);
  assign match = (rd_hash_q == hash_q) && (rd_key_q == key_q);

  assign sts_o.div_done = (div_cnt_q == HCntW'(HashBits));
  assign sts_o.empty = empty;
  assign sts_o.match = match;
  assign sts_o.last_probe = (step_q == size_q - TCntW'(1));
  assign sts_o.clr_done = (clr_idx_q == IdxW'(TableSize - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q <= key_i;
      hash_q <= (key_hash_i == '0) ? HashBits'(1) : key_hash_i;
      quot_q <= (key_hash_i == '0) ? HashBits'(1) : key_hash_i;
      prime_q <= (prime_i == '0) ? 11'd1 : prime_i;
      rem_q <= '0;
      div_cnt_q <= '0;
      mask_q <= IdxW'((TCntW'(1) << lsat) - TCntW'(1));
      size_q <= TCntW'(1) << lsat;
    end
    if (cmd_i.div_step && !sts_o.div_done) begin
      rem_q <= (rem_sh >= {1'b0, prime_q}) ? 11'(rem_sh - {1'b0, prime_q}) : rem_sh[10:0];
      quot_q <= quot_q << 1;
      div_cnt_q <= div_cnt_q + HCntW'(1);
    end
    if (cmd_i.first_probe) begin
      idx_q <= IdxW'(rem_q) & mask_q;
      step_q <= '0;
    end
    if (cmd_i.next_probe) begin
      idx_q <= (idx_q + IdxW'(step_q + TCntW'(1))) & mask_q;
      step_q <= step_q + TCntW'(1);
    end
    if (cmd_i.read) begin
      rd_hash_q <= hash_mem[idx_q];
      rd_key_q <= key_mem[idx_q];
    end
    if (cmd_i.clr_step) begin
      hash_mem[clr_idx_q] <= '0;
    end else if (cmd_i.commit && match && func_q == FUNC_REMOVE) begin
      hash_mem[idx_q] <= '0;
    end else if (cmd_i.commit && empty && func_q == FUNC_INSERT) begin
      hash_mem[idx_q] <= hash_q;
    end
    if (cmd_i.commit && func_q == FUNC_INSERT && (match || empty)) begin
      key_mem[idx_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      count_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_idx_q <= sts_o.clr_done ? '0 : clr_idx_q + IdxW'(1);
      end
      if (cmd_i.emit_clear) begin
        count_q <= '0;
      end else if (cmd_i.commit && !match && empty && func_q == FUNC_INSERT
                   && count_q < CountW'(TableSize)) begin
        count_q <= count_q + CountW'(1);
      end else if (cmd_i.commit && match && func_q == FUNC_REMOVE && count_q != '0) begin
        count_q <= count_q - CountW'(1);
      end
      if (cmd_i.commit || cmd_i.emit_clear) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_clear) begin
      rsp_q <= '0;
    end else if (cmd_i.commit) begin
      rsp_q.hit <= match;
      rsp_q.bucket_index <= BidxW'(idx_q);
      rsp_q.stored_key <= match ? OutKeyW'(rd_key_q) : '0;
      rsp_q.status <= match ? STATUS_OK : (empty ? ((func_q == FUNC_INSERT) ? STATUS_OK
                      : STATUS_NOT_FOUND) : STATUS_FULL);
      if (!match && empty && func_q == FUNC_INSERT && count_q < CountW'(TableSize)) begin
        rsp_q.entry_count <= count_q + CountW'(1);
      end else if (match && func_q == FUNC_REMOVE && count_q != '0) begin
        rsp_q.entry_count <= count_q - CountW'(1);
      end else begin
        rsp_q.entry_count <= count_q;
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TableSize)) else $error("count overflow");
  a_rsp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit || cmd_i.emit_clear) |=> rsp_o.entry_count == count_q)
    else $error("result count differs from count");
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_clear |=> count_q == '0) else $error("clear left entries");

endmodule

// ===== hdl/open_addressed_hash_set_top.sv =====
// ----------------------------------------------------------------------------
// open_addressed_hash_set_top
// Hash set with triangular probing over an on-chip bucket memory.
// ----------------------------------------------------------------------------
// A request carries func, key and key_hash on the req channel (valid/ready).
// One response per request leaves on the rsp channel (valid/ready).
// Lookup, insert and remove first reduce the hash modulo the prime with a
// restoring divider, one bit per cycle, then probe the memory, reading and
// then evaluating one bucket per probe.
// A clear sweeps the hash memory one bucket per cycle.
// One request is in flight at a time; with a ready receiver the next request
// is taken in the cycle after the response.
// After reset the block clears the hash memory before req_ready_o rises;
// configuration writes are taken during that time.
// A response waits in the output register while the receiver stalls, and no
// new request is taken until it has been delivered.
// ----------------------------------------------------------------------------
module open_addressed_hash_set_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  oahs_pkg::req_t                  req_i,
  output logic                            rsp_valid_o,
  input  logic                            rsp_ready_i,
  output oahs_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_we_i,
  input  logic [oahs_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [oahs_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import oahs_pkg::*;

  logic [PrimeW-1:0]   prime_q;
  logic [SizeLogW-1:0] size_log2_q;
  dp_cmd_t             cmd;
  dp_sts_t             sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= PrimeW'(1021);
      size_log2_q <= SizeLogW'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_PRIME: prime_q <= cfg_wdata_i;
        CFG_SIZE:  size_log2_q <= cfg_wdata_i[SizeLogW-1:0];
        default: ;
      endcase
    end
  end

  oahs_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_ready_o,
    .func_i     (req_i.func),
    .rsp_busy_i (rsp_valid_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  oahs_dp u_dp (
    .clk_i,
    .rst_ni,
    .func_i      (req_i.func),
    .key_i       (req_i.key),
    .key_hash_i  (req_i.key_hash),
    .prime_i     (prime_q),
    .size_log2_i (size_log2_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o,
    .rsp_ready_i,
    .rsp_o
  );

endmodule
